@@ hw/rtl/soms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix scan: shared definitions
// Types, field widths and register indexes used by the controller, the
// datapath and the top level.
// ----------------------------------------------------------------------------
package soms_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 4;
   localparam int IDX_W   = 3;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 1'd1;

   typedef enum logic {
      ST_LOAD,
      ST_SCAN
   } soms_state_type;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT,
      DIR_UP
   } soms_dir_type;

   typedef struct packed {
      logic store_item;
      logic scan_start;
      logic read_issue;
   } soms_cmd_type;

   typedef struct packed {
      logic load_final;
      logic out_free;
      logic scan_last;
   } soms_status_type;

endpackage

@@ hw/rtl/spiral_order_matrix_scan_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix scan unit
// Loads a matrix in row-major order and returns its elements in clockwise
// spiral order, each with its row, column and an end-of-run flag.
// ----------------------------------------------------------------------------
//  Channel  Ports                       Direction  Moves
//  req      req_valid/req_stall         in         one matrix element per item
//  rsp      rsp_valid/rsp_stall         out        one spiral element per item
//  csr      csr_write_enable/index/data in         row and column counts
//
// Each loaded element is written to the element store; the completing element starts the scan.
// The scan reads the element store once per cycle and delivers one result a
// cycle while rsp_stall is low.
// rsp_stall holds the result register and pauses the store read.
// Loading resumes once the final element has been read, even while it waits.
// Reset is synchronous and restores both counts to one.
// ----------------------------------------------------------------------------
module spiral_order_matrix_scan_unit
   import soms_pkg::*;
#(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_COLUMNS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [COUNT_W-1:0]        csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_element_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [IDX_W-1:0]          rsp_out_row,
   output logic [IDX_W-1:0]          rsp_out_column,
   output logic                      rsp_last_of_run
);

   soms_cmd_type    cmd;
   soms_status_type status;

   soms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   soms_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_element_value (req_element_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_column    (rsp_out_column),
      .rsp_last_of_run   (rsp_last_of_run),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

@@ hw/rtl/soms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix scan: controller
// Alternates between loading a matrix and walking it in spiral order.
// ----------------------------------------------------------------------------
module soms_ctrl
   import soms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  soms_status_type status,
   output soms_cmd_type    cmd
);

   soms_state_type state_ff;
   soms_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && status.load_final) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.out_free && status.scan_last) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall      = 1'b1;
      cmd.store_item = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.read_issue = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall      = 1'b0;
            cmd.store_item = req_valid;
            cmd.scan_start = req_valid && status.load_final;
         end
         ST_SCAN: begin
            cmd.read_issue = status.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule

@@ hw/rtl/soms_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix scan: datapath
// Count registers, element store, load counter, spiral position generator
// and the result register.
// ----------------------------------------------------------------------------
module soms_datapath
   import soms_pkg::*;
#(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_COLUMNS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]     csr_write_data,
   input  logic signed [VALUE_W-1:0] req_element_value,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [IDX_W-1:0]       rsp_out_row,
   output logic [IDX_W-1:0]       rsp_out_column,
   output logic                   rsp_last_of_run,
   input  soms_cmd_type           cmd,
   output soms_status_type        status
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1) + 1;
   localparam int PROD_W = 2 * COUNT_W;

   localparam logic [COUNT_W-1:0] ROWS_LIMIT = COUNT_W'(MAX_ROWS);
   localparam logic [COUNT_W-1:0] COLS_LIMIT = COUNT_W'(MAX_COLUMNS);

   logic [COUNT_W-1:0] row_count_ff;
   logic [COUNT_W-1:0] column_count_ff;
   logic [COUNT_W-1:0] rows_used;
   logic [COUNT_W-1:0] cols_used;
   logic [CNT_W-1:0]   total;

   logic [CNT_W-1:0]   load_count_ff;
   logic [CNT_W-1:0]   load_count_in;
   logic [CNT_W-1:0]   load_slot;
   logic [CNT_W-1:0]   load_next;

   logic [VALUE_W-1:0] store_mem [DEPTH];

   soms_dir_type       dir_ff;
   soms_dir_type       dir_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [IDX_W-1:0]   top_ff, top_in;
   logic [IDX_W-1:0]   bottom_ff, bottom_in;
   logic [IDX_W-1:0]   left_ff, left_in;
   logic [IDX_W-1:0]   right_ff, right_in;
   logic [CNT_W-1:0]   emit_count_ff;
   logic [CNT_W-1:0]   scan_total_ff;
   logic [COUNT_W-1:0] scan_cols_ff;
   logic [PROD_W-1:0]  read_sum;
   logic [ADDR_W-1:0]  read_addr;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic [IDX_W-1:0]   out_row_ff;
   logic [IDX_W-1:0]   out_column_ff;
   logic               out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= COUNT_W'(1);
         column_count_ff <= COUNT_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROW_COUNT:    row_count_ff    <= csr_write_data;
            CSR_COLUMN_COUNT: column_count_ff <= csr_write_data;
            default:          row_count_ff    <= row_count_ff;
         endcase
      end
   end

   always_comb begin
      rows_used = row_count_ff;
      if (row_count_ff == '0) begin
         rows_used = COUNT_W'(1);
      end else if (row_count_ff > ROWS_LIMIT) begin
         rows_used = ROWS_LIMIT;
      end
      cols_used = column_count_ff;
      if (column_count_ff == '0) begin
         cols_used = COUNT_W'(1);
      end else if (column_count_ff > COLS_LIMIT) begin
         cols_used = COLS_LIMIT;
      end
   end

   assign total     = CNT_W'(PROD_W'(rows_used) * PROD_W'(cols_used));
   assign load_slot = (load_count_ff >= total) ? '0 : load_count_ff;
   assign load_next = load_slot + CNT_W'(1);

   assign status.load_final = (load_next == total);

   always_comb begin
      load_count_in = load_count_ff;
      if (cmd.store_item) begin
         load_count_in = status.load_final ? '0 : load_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_item) begin
         store_mem[load_slot[ADDR_W-1:0]] <= req_element_value;
      end
   end

   always_comb begin
      dir_in    = dir_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      unique case (dir_ff)
         DIR_RIGHT: begin
            if (col_ff < right_ff) begin
               col_in = col_ff + IDX_W'(1);
            end else begin
               top_in = top_ff + IDX_W'(1);
               row_in = row_ff + IDX_W'(1);
               dir_in = DIR_DOWN;
            end
         end
         DIR_DOWN: begin
            if (row_ff < bottom_ff) begin
               row_in = row_ff + IDX_W'(1);
            end else begin
               right_in = right_ff - IDX_W'(1);
               col_in   = col_ff - IDX_W'(1);
               dir_in   = DIR_LEFT;
            end
         end
         DIR_LEFT: begin
            if (col_ff > left_ff) begin
               col_in = col_ff - IDX_W'(1);
            end else begin
               bottom_in = bottom_ff - IDX_W'(1);
               row_in    = row_ff - IDX_W'(1);
               dir_in    = DIR_UP;
            end
         end
         DIR_UP: begin
            if (row_ff > top_ff) begin
               row_in = row_ff - IDX_W'(1);
            end else begin
               left_in = left_ff + IDX_W'(1);
               col_in  = col_ff + IDX_W'(1);
               dir_in  = DIR_RIGHT;
            end
         end
         default: dir_in = DIR_RIGHT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= DIR_RIGHT;
         emit_count_ff <= '0;
      end else if (cmd.scan_start) begin
         dir_ff        <= DIR_RIGHT;
         emit_count_ff <= '0;
      end else if (cmd.read_issue) begin
         dir_ff        <= dir_in;
         emit_count_ff <= emit_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         row_ff        <= '0;
         col_ff        <= '0;
         top_ff        <= '0;
         left_ff       <= '0;
         bottom_ff     <= IDX_W'(rows_used - COUNT_W'(1));
         right_ff      <= IDX_W'(cols_used - COUNT_W'(1));
         scan_total_ff <= total;
         scan_cols_ff  <= cols_used;
      end else if (cmd.read_issue) begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   assign status.scan_last = (emit_count_ff == scan_total_ff - CNT_W'(1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign read_sum  = PROD_W'(row_ff) * PROD_W'(scan_cols_ff) + PROD_W'(col_ff);
   assign read_addr = read_sum[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.out_free) begin
         rsp_valid_ff <= cmd.read_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         out_value_ff  <= store_mem[read_addr];
         out_row_ff    <= row_ff;
         out_column_ff <= col_ff;
         out_last_ff   <= status.scan_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_column  = out_column_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
